// File: rtl/hta_pkg.sv
// Shared types, constants and helpers of the halftone tile averager.
// No dependencies; every other file in rtl/ imports this package.
package hta_pkg;

    localparam int MAX_TILE_COLUMNS = 1024;
    localparam int MAX_IMAGE_DIM    = 4096;
    localparam int TILE_ADDR_W      = $clog2(MAX_TILE_COLUMNS);
    localparam int POS_W            = $clog2(MAX_IMAGE_DIM);
    localparam int DIM_W            = POS_W + 1;
    localparam int STEP_W           = 6;
    localparam int SUM_W            = 20;
    localparam int AREA_W           = 2 * STEP_W;
    localparam int IDX_W            = 10;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 13;

    localparam logic [15:0] WEIGHT_RED   = 16'd19595;
    localparam logic [15:0] WEIGHT_GREEN = 16'd38470;
    localparam logic [15:0] WEIGHT_BLUE  = 16'd7471;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TILE_STEP        = 3'd0,
        CFG_SHIFT_ROWS       = 3'd1,
        CFG_MONO_MODE        = 3'd2,
        CFG_SIZE_BY_DARKNESS = 3'd3,
        CFG_IMAGE_WIDTH      = 3'd4,
        CFG_IMAGE_HEIGHT     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_DIVY,
        RS_DIVX
    } rs_state_t;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_DIV,
        PS_SQ,
        PS_MAC,
        PS_ROOT,
        PS_DONE
    } post_state_t;

    typedef struct packed {
        logic [7:0] pix_red;
        logic [7:0] pix_green;
        logic [7:0] pix_blue;
        logic       first_pixel;
    } pix_t;

    typedef struct packed {
        logic [IDX_W-1:0] tile_col;
        logic [IDX_W-1:0] tile_row;
        logic [7:0]       avg_red;
        logic [7:0]       avg_green;
        logic [7:0]       avg_blue;
        logic [7:0]       darkness;
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic [7:0]       size_factor;
        logic             visible;
        logic             frame_done;
    } tile_t;

    typedef struct packed {
        logic              valid;
        logic [STEP_W-1:0] step;
        logic [SUM_W-1:0]  sum_red;
        logic [SUM_W-1:0]  sum_green;
        logic [SUM_W-1:0]  sum_blue;
        logic [IDX_W-1:0]  tile_col;
        logic [IDX_W-1:0]  tile_row;
        logic              frame_done;
        logic              mono;
        logic              size_by_dark;
    } post_req_t;

    function automatic logic [15:0] luma_weight(input logic [1:0] ch);
        logic [15:0] w;
        unique case (ch)
            2'd0:    w = WEIGHT_RED;
            2'd1:    w = WEIGHT_GREEN;
            default: w = WEIGHT_BLUE;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/hta_post.sv
// Tile result unit: divides the three sums by the tile area, forms darkness
// by a sequential integer square root and holds the result item. Uses hta_pkg.
module hta_post import hta_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  post_req_t req,
    output logic      busy,
    output logic      tile_valid,
    input  logic      tile_stall,
    output tile_t     tile_item
);

    post_state_t       state_reg, state_next;
    logic              load_out;

    logic [AREA_W-1:0] area_reg;
    logic [SUM_W-1:0]  num_reg [3];
    logic [AREA_W-1:0] rem_reg [3];
    logic [SUM_W-1:0]  num_next [3];
    logic [AREA_W-1:0] rem_next [3];
    logic [AREA_W:0]   trial [3];
    logic [7:0]        avg_reg [3];
    logic [7:0]        avg_sat [3];
    logic [4:0]        cnt_reg;
    logic [1:0]        ch_reg;
    logic [15:0]       sq_reg;
    logic [7:0]        inv;
    logic [31:0]       prod;
    logic [31:0]       acc_reg;
    logic [31:0]       val_reg;
    logic [31:0]       root_reg;
    logic [31:0]       bit_reg;
    logic [31:0]       root_try;
    logic              root_ge;
    logic [7:0]        dark;
    logic [7:0]        size_f;
    logic [IDX_W-1:0]  col_reg, row_reg;
    logic              fd_reg, mono_reg, sbd_reg;
    logic              ov_reg;
    tile_t             item_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            trial[c] = {rem_reg[c], num_reg[c][SUM_W-1]};
            if (trial[c] >= {1'b0, area_reg})
            begin
                rem_next[c] = AREA_W'(trial[c] - {1'b0, area_reg});
                num_next[c] = {num_reg[c][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = trial[c][AREA_W-1:0];
                num_next[c] = {num_reg[c][SUM_W-2:0], 1'b0};
            end
            avg_sat[c] = (num_next[c] > SUM_W'(255)) ? 8'd255 : num_next[c][7:0];
        end
        inv      = 8'd255 - avg_reg[ch_reg];
        prod     = 32'(luma_weight(ch_reg)) * 32'(sq_reg);
        root_try = root_reg + bit_reg;
        root_ge  = val_reg >= root_try;
        dark     = (root_reg[31:16] != 16'd0) ? 8'd255 : root_reg[15:8];
        size_f   = sbd_reg ? dark : 8'd255;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            PS_IDLE: if (req.valid) state_next = PS_DIV;
            PS_DIV:  if (cnt_reg == 5'(SUM_W - 1)) state_next = PS_SQ;
            PS_SQ:   state_next = PS_MAC;
            PS_MAC:  state_next = (ch_reg == 2'd2) ? PS_ROOT : PS_SQ;
            PS_ROOT: if (cnt_reg == 5'd15) state_next = PS_DONE;
            PS_DONE: if (load_out) state_next = PS_IDLE;
            default: state_next = PS_IDLE;
        endcase
    end

    always_comb
    begin
        busy     = (state_reg != PS_IDLE);
        load_out = (state_reg == PS_DONE) && (!ov_reg || !tile_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                ov_reg <= 1'b1;
            else if (!tile_stall)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            PS_IDLE:
            begin
                area_reg   <= AREA_W'(AREA_W'(req.step) * AREA_W'(req.step));
                num_reg[0] <= req.sum_red;
                num_reg[1] <= req.sum_green;
                num_reg[2] <= req.sum_blue;
                for (int c = 0; c < 3; c++)
                    rem_reg[c] <= '0;
                cnt_reg    <= '0;
                col_reg    <= req.tile_col;
                row_reg    <= req.tile_row;
                fd_reg     <= req.frame_done;
                mono_reg   <= req.mono;
                sbd_reg    <= req.size_by_dark;
            end
            PS_DIV:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    num_reg[c] <= num_next[c];
                    rem_reg[c] <= rem_next[c];
                    avg_reg[c] <= avg_sat[c];
                end
                cnt_reg <= cnt_reg + 5'd1;
                ch_reg  <= '0;
                acc_reg <= '0;
            end
            PS_SQ:
                sq_reg <= 16'(inv) * 16'(inv);
            PS_MAC:
            begin
                acc_reg  <= acc_reg + prod;
                val_reg  <= acc_reg + prod;
                ch_reg   <= ch_reg + 2'd1;
                cnt_reg  <= '0;
                root_reg <= '0;
                bit_reg  <= 32'h4000_0000;
            end
            PS_ROOT:
            begin
                if (root_ge)
                begin
                    val_reg  <= val_reg - root_try;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
            end
            PS_DONE:
            begin
                if (load_out)
                begin
                    item_reg.tile_col    <= col_reg;
                    item_reg.tile_row    <= row_reg;
                    item_reg.avg_red     <= avg_reg[0];
                    item_reg.avg_green   <= avg_reg[1];
                    item_reg.avg_blue    <= avg_reg[2];
                    item_reg.darkness    <= dark;
                    item_reg.out_red     <= mono_reg ? 8'd255 - dark : avg_reg[0];
                    item_reg.out_green   <= mono_reg ? 8'd255 - dark : avg_reg[1];
                    item_reg.out_blue    <= mono_reg ? 8'd255 - dark : avg_reg[2];
                    item_reg.size_factor <= size_f;
                    item_reg.visible     <= (size_f != 8'd0);
                    item_reg.frame_done  <= fd_reg;
                end
            end
            default: ;
        endcase
    end

    assign tile_valid = ov_reg;
    assign tile_item  = item_reg;

endmodule

// File: rtl/halftone_tile_averager.sv
// Top level of the halftone tile averager: position tracking, tile sum
// memory with read-modify-write, configuration. Uses hta_pkg and hta_post.
//
// Usage:
//   pix channel: one RGB pixel per item in raster order; first_pixel restarts
//   the frame at the top-left corner. An item is taken when pix_valid is high
//   and pix_stall is low.
//   tile channel: one item per completed tile, taken when tile_valid is high
//   and tile_stall is low; the item holds while stalled.
//   cfg channel: register writes by index, always ready; write only while no
//   item is in flight.
// Throughput: one pixel per cycle while pix_stall is low, set by the
//   read-modify-write of the tile sum memory (one read and one write each
//   cycle, with bypass). Tile completion: the pixel that ends a tile is
//   registered, handed to the result unit and passed through the division
//   steps, the multiply steps, the square-root steps and the output load;
//   pix_stall stays high over that time.
// After any configuration write, position tracking is rebuilt by a row
//   division and, when needed, a column division, with pix_stall high.
// Reset: registers take their defaults, counters return to the top-left.
//   Tile memory is not cleared; each tile's first pixel overwrites its entry.
// A stalled tile item stalls the pixel channel once the next tile completes.
module halftone_tile_averager import hta_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_stall,
    input  pix_t                   pix_item,
    output logic                   tile_valid,
    input  logic                   tile_stall,
    output tile_t                  tile_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [STEP_W-1:0] tile_step_reg;
    logic              shift_rows_reg, mono_mode_reg, size_by_dark_reg;
    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [STEP_W-1:0] step_eff, half_step;
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic              cfg_wr;

    logic [POS_W-1:0]  cx_reg, cy_reg, ty_reg, k_reg;
    logic [STEP_W-1:0] ry_reg, ox_reg;
    logic              par_reg, in_reg;

    logic [POS_W-1:0]  cur_cx, cur_cy, cur_ty, cur_k;
    logic [STEP_W-1:0] cur_ry, cur_ox, xs_cur, xs_line;
    logic              cur_par, cur_in;
    logic [POS_W-1:0]  nx_cx, nx_cy, nx_ty, nx_k;
    logic [STEP_W-1:0] nx_ry, nx_ox;
    logic              nx_par, nx_in;
    logic              pos_ok, is_first, is_last, is_fd, accept;

    rs_state_t         rs_state_reg, rs_state_next;
    logic              rs_busy;
    logic [POS_W-1:0]  rs_num_reg, rs_num_next;
    logic [STEP_W-1:0] rs_rem_reg, rs_rem_next;
    logic [STEP_W:0]   rs_trial;
    logic [3:0]        rs_cnt_reg;
    logic              rs_last;
    logic              rs_par;
    logic [STEP_W-1:0] rs_xs;

    logic [3*SUM_W-1:0] tile_mem [MAX_TILE_COLUMNS];
    logic [3*SUM_W-1:0] rd_reg, byp_data_reg, base, new_sum;
    logic               byp_reg;
    logic               s1_valid_reg, s1_first_reg, s1_last_reg, s1_fd_reg;
    logic [TILE_ADDR_W-1:0] s1_k_reg;
    logic [IDX_W-1:0]   s1_ty_reg;
    logic [23:0]        s1_pix_reg;

    post_req_t          req;
    logic               post_busy;

    // configuration
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_step_reg    <= STEP_W'(25);
            shift_rows_reg   <= 1'b0;
            mono_mode_reg    <= 1'b0;
            size_by_dark_reg <= 1'b0;
            width_reg        <= DIM_W'(1024);
            height_reg       <= DIM_W'(768);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_TILE_STEP:        tile_step_reg    <= cfg_data[STEP_W-1:0];
                CFG_SHIFT_ROWS:       shift_rows_reg   <= cfg_data[0];
                CFG_MONO_MODE:        mono_mode_reg    <= cfg_data[0];
                CFG_SIZE_BY_DARKNESS: size_by_dark_reg <= cfg_data[0];
                CFG_IMAGE_WIDTH:      width_reg        <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:     height_reg       <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        step_eff  = (tile_step_reg == '0) ? STEP_W'(1) : tile_step_reg;
        half_step = step_eff >> 1;
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_IMAGE_DIM))
            w_eff = DIM_W'(MAX_IMAGE_DIM);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_IMAGE_DIM))
            h_eff = DIM_W'(MAX_IMAGE_DIM);
        else
            h_eff = height_reg;
    end

    // position of the current pixel and of the next one
    always_comb
    begin
        if (pix_item.first_pixel)
        begin
            cur_cx  = '0;
            cur_cy  = '0;
            cur_ty  = '0;
            cur_ry  = '0;
            cur_par = 1'b0;
            cur_in  = shift_rows_reg || (half_step == '0);
            cur_k   = '0;
            cur_ox  = '0;
        end
        else
        begin
            cur_cx  = cx_reg;
            cur_cy  = cy_reg;
            cur_ty  = ty_reg;
            cur_ry  = ry_reg;
            cur_par = par_reg;
            cur_in  = in_reg;
            cur_k   = k_reg;
            cur_ox  = ox_reg;
        end
        xs_cur   = (shift_rows_reg && !cur_par) ? '0 : half_step;
        pos_ok   = ({1'b0, cur_cx} < w_eff) && ({1'b0, cur_cy} < h_eff) && cur_in
                   && (cur_k < POS_W'(MAX_TILE_COLUMNS));
        is_first = (cur_ry == '0) && (cur_ox == '0);
        is_last  = ((cur_ox == step_eff - STEP_W'(1)) || ({1'b0, cur_cx} == w_eff - DIM_W'(1)))
                && ((cur_ry == step_eff - STEP_W'(1)) || ({1'b0, cur_cy} == h_eff - DIM_W'(1)));
        is_fd    = ({1'b0, cur_cx} == w_eff - DIM_W'(1))
                && ({1'b0, cur_cy} == h_eff - DIM_W'(1));

        nx_cy  = cur_cy;
        nx_ty  = cur_ty;
        nx_ry  = cur_ry;
        nx_par = cur_par;
        nx_in  = cur_in;
        nx_k   = cur_k;
        nx_ox  = cur_ox;
        xs_line = '0;
        if ({1'b0, cur_cx} + DIM_W'(1) >= w_eff)
        begin
            nx_cx = '0;
            if ({1'b0, cur_cy} + DIM_W'(1) >= h_eff)
            begin
                nx_cy  = '0;
                nx_ty  = '0;
                nx_ry  = '0;
                nx_par = 1'b0;
            end
            else
            begin
                nx_cy = cur_cy + POS_W'(1);
                if (cur_ry + STEP_W'(1) == step_eff)
                begin
                    nx_ry  = '0;
                    nx_ty  = cur_ty + POS_W'(1);
                    nx_par = cur_par ^ step_eff[0];
                end
                else
                    nx_ry = cur_ry + STEP_W'(1);
            end
            xs_line = (shift_rows_reg && !nx_par) ? '0 : half_step;
            nx_in   = (xs_line == '0);
            nx_k    = '0;
            nx_ox   = '0;
        end
        else
        begin
            nx_cx = cur_cx + POS_W'(1);
            if (cur_in)
            begin
                if (cur_ox + STEP_W'(1) == step_eff)
                begin
                    nx_ox = '0;
                    nx_k  = cur_k + POS_W'(1);
                end
                else
                    nx_ox = cur_ox + STEP_W'(1);
            end
            else if (cur_cx + POS_W'(1) == POS_W'(xs_cur))
            begin
                nx_in = 1'b1;
                nx_k  = '0;
                nx_ox = '0;
            end
        end
    end

    assign pix_stall = rs_busy || post_busy || (s1_valid_reg && s1_last_reg);
    assign accept    = pix_valid && !pix_stall;

    // rebuild of the tile position after configuration
    always_comb
    begin
        rs_trial = {rs_rem_reg, rs_num_reg[POS_W-1]};
        if (rs_trial >= {1'b0, step_eff})
        begin
            rs_rem_next = STEP_W'(rs_trial - {1'b0, step_eff});
            rs_num_next = {rs_num_reg[POS_W-2:0], 1'b1};
        end
        else
        begin
            rs_rem_next = rs_trial[STEP_W-1:0];
            rs_num_next = {rs_num_reg[POS_W-2:0], 1'b0};
        end
        rs_last = (rs_cnt_reg == 4'(POS_W - 1));
        rs_par  = rs_num_next[0] & step_eff[0];
        rs_xs   = (shift_rows_reg && !rs_par) ? '0 : half_step;
    end

    always_comb
    begin
        rs_state_next = rs_state_reg;
        unique case (rs_state_reg)
            RS_IDLE: if (cfg_wr) rs_state_next = RS_DIVY;
            RS_DIVY:
            begin
                if (cfg_wr)
                    rs_state_next = RS_DIVY;
                else if (rs_last)
                    rs_state_next = (cx_reg >= POS_W'(rs_xs)) ? RS_DIVX : RS_IDLE;
            end
            RS_DIVX:
            begin
                if (cfg_wr)
                    rs_state_next = RS_DIVY;
                else if (rs_last)
                    rs_state_next = RS_IDLE;
            end
            default: rs_state_next = RS_IDLE;
        endcase
    end

    always_comb
    begin
        rs_busy = (rs_state_reg != RS_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_state_reg <= RS_IDLE;
            cx_reg       <= '0;
            cy_reg       <= '0;
            ty_reg       <= '0;
            ry_reg       <= '0;
            par_reg      <= 1'b0;
            in_reg       <= 1'b0;
            k_reg        <= '0;
            ox_reg       <= '0;
            rs_num_reg   <= '0;
            rs_rem_reg   <= '0;
            rs_cnt_reg   <= '0;
        end
        else
        begin
            rs_state_reg <= rs_state_next;
            if (cfg_wr)
            begin
                rs_num_reg <= cy_reg;
                rs_rem_reg <= '0;
                rs_cnt_reg <= '0;
            end
            else if (rs_busy)
            begin
                if (rs_last && rs_state_reg == RS_DIVY)
                begin
                    ty_reg     <= rs_num_next;
                    ry_reg     <= rs_rem_next;
                    par_reg    <= rs_par;
                    in_reg     <= (cx_reg >= POS_W'(rs_xs));
                    k_reg      <= '0;
                    ox_reg     <= '0;
                    rs_num_reg <= cx_reg - POS_W'(rs_xs);
                    rs_rem_reg <= '0;
                    rs_cnt_reg <= '0;
                end
                else
                begin
                    rs_num_reg <= rs_num_next;
                    rs_rem_reg <= rs_rem_next;
                    rs_cnt_reg <= rs_cnt_reg + 4'd1;
                    if (rs_last)
                    begin
                        k_reg  <= rs_num_next;
                        ox_reg <= rs_rem_next;
                    end
                end
            end
            else if (accept)
            begin
                cx_reg  <= nx_cx;
                cy_reg  <= nx_cy;
                ty_reg  <= nx_ty;
                ry_reg  <= nx_ry;
                par_reg <= nx_par;
                in_reg  <= nx_in;
                k_reg   <= nx_k;
                ox_reg  <= nx_ox;
            end
        end
    end

    // tile sum read-modify-write
    always_comb
    begin
        base = s1_first_reg ? '0 : (byp_reg ? byp_data_reg : rd_reg);
        new_sum[3*SUM_W-1:2*SUM_W] = base[3*SUM_W-1:2*SUM_W] + SUM_W'(s1_pix_reg[23:16]);
        new_sum[2*SUM_W-1:SUM_W]   = base[2*SUM_W-1:SUM_W]   + SUM_W'(s1_pix_reg[15:8]);
        new_sum[SUM_W-1:0]         = base[SUM_W-1:0]         + SUM_W'(s1_pix_reg[7:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && pos_ok;
            byp_reg      <= accept && pos_ok && s1_valid_reg
                            && (cur_k[TILE_ADDR_W-1:0] == s1_k_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= new_sum;
        if (s1_valid_reg)
            tile_mem[s1_k_reg] <= new_sum;
        if (accept)
        begin
            rd_reg       <= tile_mem[cur_k[TILE_ADDR_W-1:0]];
            s1_k_reg     <= cur_k[TILE_ADDR_W-1:0];
            s1_first_reg <= is_first;
            s1_last_reg  <= is_last;
            s1_fd_reg    <= is_fd;
            s1_ty_reg    <= cur_ty[IDX_W-1:0];
            s1_pix_reg   <= {pix_item.pix_red, pix_item.pix_green, pix_item.pix_blue};
        end
    end

    always_comb
    begin
        req.valid        = s1_valid_reg && s1_last_reg;
        req.step         = step_eff;
        req.sum_red      = new_sum[3*SUM_W-1:2*SUM_W];
        req.sum_green    = new_sum[2*SUM_W-1:SUM_W];
        req.sum_blue     = new_sum[SUM_W-1:0];
        req.tile_col     = IDX_W'(s1_k_reg);
        req.tile_row     = s1_ty_reg;
        req.frame_done   = s1_fd_reg;
        req.mono         = mono_mode_reg;
        req.size_by_dark = size_by_dark_reg;
    end

    hta_post u_post
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .busy       (post_busy),
        .tile_valid (tile_valid),
        .tile_stall (tile_stall),
        .tile_item  (tile_item)
    );

    a_post_free: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg |-> !post_busy)
        else $error("tile completed while result unit busy");

    a_track_range: assert property (@(posedge clk) disable iff (!rst_n)
        rs_state_reg == RS_IDLE |-> (ox_reg < step_eff) && (ry_reg < step_eff))
        else $error("tile offset out of range");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        post_busy || rs_busy |-> !accept)
        else $error("pixel taken while busy");

endmodule

// File: test/hta_checker.sv
// Checker for the halftone tile averager: watches the pixel, tile and config
// channels, predicts each tile item and compares it field by field.
// Depends on hta_pkg for the item types and register indexes.
`timescale 1ns / 1ps

module hta_checker import hta_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    input  logic                   pix_stall,
    input  pix_t                   pix_item,
    input  logic                   tile_valid,
    input  logic                   tile_stall,
    input  tile_t                  tile_item,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     pending,
    output int                     errors
);

    int unsigned step_r, shift_r, mono_r, size_r, width_r, height_r;
    int unsigned col_pos, row_pos;
    logic [SUM_W-1:0] red_sum [MAX_TILE_COLUMNS];
    logic [SUM_W-1:0] green_sum [MAX_TILE_COLUMNS];
    logic [SUM_W-1:0] blue_sum [MAX_TILE_COLUMNS];
    tile_t tiles_due [$];

    function automatic int unsigned root_of(longint unsigned v);
        longint unsigned r;
        longint unsigned c;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return int'(r);
    endfunction

    function automatic int unsigned limit_dim(int unsigned d);
        if (d < 1)
            return 1;
        if (d > MAX_IMAGE_DIM)
            return MAX_IMAGE_DIM;
        return d;
    endfunction

    task automatic take_pixel(pix_t p);
        int unsigned w, h, s, cx, cy, ty, y0, xs, k, x0, xl, yl, dark, sf;
        int unsigned avg [3];
        longint unsigned rf, gf, bf;
        logic [SUM_W-1:0] ns [3];
        bit first;
        tile_t t;
        w = limit_dim(width_r);
        h = limit_dim(height_r);
        s = (step_r == 0) ? 1 : step_r;
        if (p.first_pixel)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        cx = col_pos;
        cy = row_pos;
        if (cx < w && cy < h)
        begin
            ty = cy / s;
            y0 = ty * s;
            xs = (shift_r != 0 && y0 % 2 == 0) ? 0 : s / 2;
            if (cx >= xs && (cx - xs) / s < MAX_TILE_COLUMNS)
            begin
                k = (cx - xs) / s;
                x0 = xs + k * s;
                first = (cy == y0) && (cx == x0);
                xl = (x0 + s < w) ? x0 + s - 1 : w - 1;
                yl = (y0 + s < h) ? y0 + s - 1 : h - 1;
                ns[0] = (first ? '0 : red_sum[k]) + p.pix_red;
                ns[1] = (first ? '0 : green_sum[k]) + p.pix_green;
                ns[2] = (first ? '0 : blue_sum[k]) + p.pix_blue;
                red_sum[k] = ns[0];
                green_sum[k] = ns[1];
                blue_sum[k] = ns[2];
                if (cx == xl && cy == yl)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        avg[c] = ns[c] / (s * s);
                        if (avg[c] > 255)
                            avg[c] = 255;
                    end
                    rf = 255 - avg[0];
                    gf = 255 - avg[1];
                    bf = 255 - avg[2];
                    dark = root_of(WEIGHT_RED * rf * rf + WEIGHT_GREEN * gf * gf
                                   + WEIGHT_BLUE * bf * bf) / 256;
                    if (dark > 255)
                        dark = 255;
                    sf = (size_r != 0) ? dark : 255;
                    t.tile_col = k[IDX_W-1:0];
                    t.tile_row = ty[IDX_W-1:0];
                    t.avg_red = avg[0][7:0];
                    t.avg_green = avg[1][7:0];
                    t.avg_blue = avg[2][7:0];
                    t.darkness = dark[7:0];
                    t.out_red = (mono_r != 0) ? 8'(255 - dark) : avg[0][7:0];
                    t.out_green = (mono_r != 0) ? 8'(255 - dark) : avg[1][7:0];
                    t.out_blue = (mono_r != 0) ? 8'(255 - dark) : avg[2][7:0];
                    t.size_factor = sf[7:0];
                    t.visible = (sf != 0);
                    t.frame_done = (cx == w - 1 && cy == h - 1);
                    tiles_due.push_back(t);
                end
            end
        end
        if (cx + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (cy + 1 >= h) ? 0 : cy + 1;
        end
        else
            col_pos = cx + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tile_t e;
        if (!rst_n)
        begin
            step_r = 25;
            shift_r = 0;
            mono_r = 0;
            size_r = 0;
            width_r = 1024;
            height_r = 768;
            col_pos = 0;
            row_pos = 0;
            tiles_due.delete();
            errors = 0;
        end
        else
        begin
            if (tile_valid && !tile_stall)
            begin
                if (tiles_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected tile item %p", tile_item);
                end
                else
                begin
                    e = tiles_due.pop_front();
                    if (e.tile_col !== tile_item.tile_col || e.tile_row !== tile_item.tile_row
                        || e.avg_red !== tile_item.avg_red
                        || e.avg_green !== tile_item.avg_green
                        || e.avg_blue !== tile_item.avg_blue
                        || e.darkness !== tile_item.darkness
                        || e.out_red !== tile_item.out_red
                        || e.out_green !== tile_item.out_green
                        || e.out_blue !== tile_item.out_blue
                        || e.size_factor !== tile_item.size_factor
                        || e.visible !== tile_item.visible
                        || e.frame_done !== tile_item.frame_done)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("tile mismatch: expected %p actual %p", e, tile_item);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TILE_STEP:        step_r = cfg_data[5:0];
                    CFG_SHIFT_ROWS:       shift_r = cfg_data[0];
                    CFG_MONO_MODE:        mono_r = cfg_data[0];
                    CFG_SIZE_BY_DARKNESS: size_r = cfg_data[0];
                    CFG_IMAGE_WIDTH:      width_r = cfg_data;
                    CFG_IMAGE_HEIGHT:     height_r = cfg_data;
                    default: ;
                endcase
            end
            if (pix_valid && !pix_stall)
                take_pixel(pix_item);
        end
        pending = tiles_due.size();
    end

endmodule

// File: test/testbench.sv
// Top of the halftone tile averager testbench: clock, reset, pixel and config
// stimulus, tile receiver with random stalls, and the verdict.
// Depends on hta_pkg, halftone_tile_averager and hta_checker.
`timescale 1ns / 1ps

module testbench import hta_pkg::*;;

    typedef struct {
        int step, shift, mono, sz, w, h, n, fill;
    } frame_setup_t;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_WHITE  = 1;
    localparam int FILL_BLACK  = 2;
    localparam int FILL_EDGES  = 3;

    logic clk;
    logic rst_n;
    logic pix_valid;
    logic pix_stall;
    pix_t pix_item;
    logic tile_valid;
    logic tile_stall;
    tile_t tile_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int pending;
    int errors;
    bit send_quiet;
    bit recv_quiet;
    bit hold_request;

    halftone_tile_averager u_top (.*);

    hta_checker u_checker (.*);

    initial
    begin
        clk = 0;
        forever
        begin
            #4 clk = 1;
            #4 clk = 0;
        end
    end

    initial
    begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        tile_stall = 1;
        hold_request = 0;
        @(posedge rst_n);
        forever
        begin
            int n;
            n = recv_quiet ? 0 : $urandom_range(0, 19);
            if (hold_request)
            begin
                hold_request = 0;
                n = 1500;
            end
            if (n > 0)
            begin
                tile_stall <= 1;
                repeat (n) @(posedge clk);
            end
            tile_stall <= 0;
            do @(posedge clk); while (!tile_valid);
        end
    end

    task automatic write_reg(cfg_reg_t idx, int value);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic send_pixel(pix_t p);
        int n;
        n = send_quiet ? 0 : $urandom_range(0, 19);
        if (n > 0)
        begin
            pix_valid <= 0;
            repeat (n) @(posedge clk);
        end
        pix_item <= p;
        pix_valid <= 1;
        do @(posedge clk); while (pix_stall);
    endtask

    task automatic run_frame(frame_setup_t f);
        pix_t p;
        int v;
        pix_valid <= 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (60) @(posedge clk);
        write_reg(CFG_TILE_STEP, f.step);
        write_reg(CFG_SHIFT_ROWS, f.shift);
        write_reg(CFG_MONO_MODE, f.mono);
        write_reg(CFG_SIZE_BY_DARKNESS, f.sz);
        write_reg(CFG_IMAGE_WIDTH, f.w);
        write_reg(CFG_IMAGE_HEIGHT, f.h);
        cfg_valid <= 0;
        for (int i = 0; i < f.n; i++)
        begin
            if (i % 40 == 0)
            begin
                send_quiet = ($urandom_range(0, 3) == 0);
                recv_quiet = ($urandom_range(0, 3) == 0);
            end
            case (f.fill)
                FILL_WHITE: p = {8'hFF, 8'hFF, 8'hFF, 1'b0};
                FILL_BLACK: p = {8'h00, 8'h00, 8'h00, 1'b0};
                FILL_EDGES:
                begin
                    v = $urandom_range(0, 3);
                    p.pix_red = (v == 0) ? 8'h00 : (v == 1) ? 8'hFF : (v == 2) ? 8'hAA : 8'h55;
                    p.pix_green = ~p.pix_red;
                    p.pix_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
                default: p = {8'($urandom), 8'($urandom), 8'($urandom), 1'b0};
            endcase
            p.first_pixel = (i == 0) || ($urandom_range(0, 299) == 0);
            send_pixel(p);
        end
    endtask

    initial
    begin
        frame_setup_t f;
        int odd;
        rst_n = 0;
        pix_valid = 0;
        pix_item = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        send_quiet = 0;
        recv_quiet = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        run_frame('{5, 1, 0, 1, 12, 11, 132, FILL_WHITE});
        run_frame('{5, 0, 1, 0, 7, 5, 35, FILL_BLACK});
        run_frame('{0, 1, 1, 1, 3, 2, 12, FILL_EDGES});
        run_frame('{63, 1, 0, 0, 0, 8191, 70, FILL_RANDOM});
        run_frame('{63, 0, 1, 1, 4096, 1, 40, FILL_RANDOM});
        run_frame('{1, 0, 0, 1, 1026, 1, 1026, FILL_RANDOM});
        for (int ph = 0; ph < 7; ph++)
        begin
            odd = 2 * $urandom_range(2, 25) + 1;
            f.step = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : odd;
            f.shift = $urandom_range(0, 1);
            f.mono = $urandom_range(0, 1);
            f.sz = $urandom_range(0, 1);
            f.w = $urandom_range(1, 7);
            f.h = $urandom_range(1, 7);
            f.n = f.w * f.h + $urandom_range(0, 4);
            f.fill = ($urandom_range(0, 5) == 0) ? FILL_EDGES : FILL_RANDOM;
            if (ph == 3)
            begin
                f = '{5, 1, 0, 1, 8, 8, 64, FILL_RANDOM};
                hold_request = 1;
            end
            run_frame(f);
        end
        pix_valid <= 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
